// ===== hdl/spsch_pkg.sv =====
package spsch_pkg;

    localparam int CHANNELS_DEF   = 32;
    localparam int GROUP_SIZE_DEF = 8;

    localparam int CH_W    = 5;
    localparam int WUS_W   = 12;
    localparam int WID_W   = 8;
    localparam int TICK_W  = 11;
    localparam int PINS_W  = 32;
    localparam int CMP_W   = 16;

    localparam int GROUP_SPACING = 251;
    localparam int FRAME_TICKS   = 2000;
    localparam int WINDOW_OPEN   = 1100;
    localparam int WINDOW_CLOSE  = 1900;
    localparam int MIN_WIDTH_US  = 500;
    localparam int MAX_WIDTH_US  = 2500;

    // floor(x / 10) == (x * 3277) >> 15 for x up to 2500
    localparam int RECIP       = 3277;
    localparam int RECIP_SHIFT = 15;
    localparam int PROD_W      = 24;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [CH_W-1:0]  channel;
        logic [WUS_W-1:0] width_us;
    } t_in_item;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              update_open;
        logic              rejected;
    } t_out_item;

    typedef struct packed {
        logic             tick;
        logic             wr_en;
        logic [CH_W-1:0]  wr_ch;
        logic [WID_W-1:0] wr_val;
    } t_upd;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              window;
    } t_view;

endpackage

// ===== hdl/spsch_cmd_decode.sv =====
module spsch_cmd_decode #(
    parameter int CHANNELS = spsch_pkg::CHANNELS_DEF
) (
    input  logic                  i_fire,
    input  spsch_pkg::t_in_item   i_item,
    output spsch_pkg::t_upd       o_upd,
    output logic                  o_rejected
);

    localparam int CHX_W = spsch_pkg::CH_W + 2;

    logic [spsch_pkg::PROD_W-1:0]  prod;
    logic [spsch_pkg::WID_W-1:0]   units;
    logic                          ch_bad;
    logic                          wus_zero;
    logic                          wus_ok;
    logic                          is_set;
    logic                          rej;

    assign prod  = spsch_pkg::PROD_W'(i_item.width_us)
                 * spsch_pkg::PROD_W'(spsch_pkg::RECIP);
    assign units = prod[spsch_pkg::RECIP_SHIFT +: spsch_pkg::WID_W];

    assign ch_bad   = CHX_W'(i_item.channel) >= CHX_W'(CHANNELS);
    assign wus_zero = i_item.width_us == '0;
    assign wus_ok   = (i_item.width_us >= spsch_pkg::WUS_W'(spsch_pkg::MIN_WIDTH_US))
                   && (i_item.width_us <= spsch_pkg::WUS_W'(spsch_pkg::MAX_WIDTH_US));
    assign is_set   = i_item.cmd == spsch_pkg::CMD_SET;
    assign rej      = is_set && (ch_bad || !(wus_zero || wus_ok));

    assign o_rejected   = rej;
    assign o_upd.tick   = i_fire && (i_item.cmd == spsch_pkg::CMD_TICK);
    assign o_upd.wr_en  = i_fire && is_set && !rej;
    assign o_upd.wr_ch  = i_item.channel;
    assign o_upd.wr_val = wus_zero ? '0 : units;

endmodule

// ===== hdl/spsch_frame.sv =====
module spsch_frame #(
    parameter int CHANNELS   = spsch_pkg::CHANNELS_DEF,
    parameter int GROUP_SIZE = spsch_pkg::GROUP_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spsch_pkg::t_upd  i_upd,
    output spsch_pkg::t_view o_view
);

    localparam int VIS = (CHANNELS < spsch_pkg::PINS_W) ? CHANNELS : spsch_pkg::PINS_W;
    localparam int CMP_W = spsch_pkg::CMP_W;

    logic [spsch_pkg::WID_W-1:0]  r_store [VIS];
    logic [spsch_pkg::WID_W-1:0]  n_store [VIS];
    logic [spsch_pkg::WID_W-1:0]  r_frame [VIS];
    logic [spsch_pkg::WID_W-1:0]  n_frame [VIS];
    logic [spsch_pkg::TICK_W-1:0] r_tick;
    logic [spsch_pkg::TICK_W-1:0] n_tick;
    logic                         r_window;
    logic                         n_window;
    logic                         wrap;
    logic [CMP_W-1:0]             t_ext;
    logic [VIS-1:0]               pins_vis;

    assign wrap = r_tick == spsch_pkg::TICK_W'(spsch_pkg::FRAME_TICKS - 1);

    always_comb begin
        n_store  = r_store;
        n_frame  = r_frame;
        n_tick   = r_tick;
        n_window = r_window;
        for (int k = 0; k < VIS; k++) begin
            if (i_upd.wr_en && i_upd.wr_ch == spsch_pkg::CH_W'(k)) begin
                n_store[k] = i_upd.wr_val;
            end
        end
        if (i_upd.tick) begin
            if (wrap) begin
                n_tick  = '0;
                n_frame = r_store;
            end else begin
                n_tick = r_tick + 1'b1;
            end
            n_window = (n_tick >= spsch_pkg::TICK_W'(spsch_pkg::WINDOW_OPEN))
                    && (n_tick <  spsch_pkg::TICK_W'(spsch_pkg::WINDOW_CLOSE));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VIS; k++) begin
                r_store[k] <= '0;
                r_frame[k] <= '0;
            end
            r_tick   <= '0;
            r_window <= 1'b0;
        end else begin
            r_store  <= n_store;
            r_frame  <= n_frame;
            r_tick   <= n_tick;
            r_window <= n_window;
        end
    end

    assign t_ext = CMP_W'(n_tick);

    for (genvar n = 0; n < VIS; n++) begin : g_pin
        localparam logic [CMP_W-1:0] START =
            CMP_W'(spsch_pkg::GROUP_SPACING * (n / GROUP_SIZE));
        logic [CMP_W-1:0] stop;
        assign stop        = START + CMP_W'(n_frame[n]);
        assign pins_vis[n] = (t_ext >= START) && (t_ext < stop);
    end

    assign o_view.pins   = spsch_pkg::PINS_W'(pins_vis);
    assign o_view.window = n_window;

    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < spsch_pkg::TICK_W'(spsch_pkg::FRAME_TICKS))
        else $error("tick count out of frame");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_upd.tick) && $past(wrap) |-> r_tick == '0)
        else $error("frame did not wrap");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_upd.tick) |-> $stable(r_tick) && $stable(r_window))
        else $error("frame position moved without a tick");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_window == ((r_tick >= spsch_pkg::TICK_W'(spsch_pkg::WINDOW_OPEN))
                  && (r_tick <  spsch_pkg::TICK_W'(spsch_pkg::WINDOW_CLOSE))))
        else $error("update window flag out of step with tick");

endmodule

// ===== hdl/servo_pulse_scheduler.sv =====
// channel  dir  handshake                  beat payload
// in       in   i_in_valid / o_in_ready    i_in_data  (spsch_pkg::t_in_item)
// out      out  o_out_valid / i_out_ready  o_out_data (spsch_pkg::t_out_item)
//
// One beat in and one beat out per cycle while results are taken; each input beat gives one result beat.
// Stages: input register, then decode and frame update into the result register.
// Synchronous active-low reset clears both width tables, the tick count and the window flag.
// A held result stalls both stages; o_in_ready drops only while the input register is full too.
module servo_pulse_scheduler #(
    parameter int CHANNELS   = spsch_pkg::CHANNELS_DEF,
    parameter int GROUP_SIZE = spsch_pkg::GROUP_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  spsch_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output spsch_pkg::t_out_item o_out_data
);

    spsch_pkg::t_in_item  r_in;
    logic                 r_in_vld;
    spsch_pkg::t_out_item r_out;
    logic                 r_out_vld;
    logic                 adv;
    logic                 fire;
    spsch_pkg::t_upd      upd;
    logic                 rejected;
    spsch_pkg::t_view     view;

    assign adv        = !r_out_vld || i_out_ready;
    assign fire       = r_in_vld && adv;
    assign o_in_ready = !r_in_vld || adv;

    spsch_cmd_decode #(
        .CHANNELS (CHANNELS)
    ) u_decode (
        .i_fire     (fire),
        .i_item     (r_in),
        .o_upd      (upd),
        .o_rejected (rejected)
    );

    spsch_frame #(
        .CHANNELS   (CHANNELS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (adv) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out.pins        <= view.pins;
            r_out.update_open <= view.window;
            r_out.rejected    <= rejected;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(fire) |-> o_out_valid)
        else $error("result beat lost");

    a_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(fire) && $past(r_in.cmd) == spsch_pkg::CMD_TICK
        |-> !r_out.rejected)
        else $error("tick beat flagged as rejected");

    a_no_write_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rejected |-> !upd.wr_en && !upd.tick)
        else $error("rejected command changed state");

endmodule
